[rtl/b64u_pkg.sv]
`default_nettype none
package b64u_pkg;

   localparam int MaxResults = 4;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] TEXT_LOW   = 8'd32;
   localparam logic [7:0] TEXT_HIGH  = 8'd126;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;

   typedef enum logic [1:0] {
      MODE_UNDECIDED = 2'd0,
      MODE_RAW       = 2'd1,
      MODE_UTF16     = 2'd2
   } mode_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       message_end;
      logic       no_payload;
   } result_type;

   typedef struct packed {
      logic [2:0]                      count;
      result_type [MaxResults-1:0]     entry;
   } batch_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.ok    = 1'b1;
      s.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         s.value = 6'd62;
      end else if (c == 8'h2F) begin
         s.value = 6'd63;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

   function automatic logic is_text(input logic [7:0] lo, input logic [7:0] hi);
      return (hi == 8'd0) && (((lo >= TEXT_LOW) && (lo <= TEXT_HIGH)) ||
             (lo == CHAR_TAB) || (lo == CHAR_LF) || (lo == CHAR_CR));
   endfunction

   // append one result; drop it once the batch is full
   function automatic batch_type push(input batch_type b, input result_type r);
      batch_type nb;
      nb = b;
      if (b.count < 3'(MaxResults)) begin
         nb.entry[b.count[1:0]] = r;
         nb.count = b.count + 3'd1;
      end
      return nb;
   endfunction

   function automatic result_type data_result(input logic [7:0] value);
      result_type r;
      r.out_byte    = value;
      r.byte_valid  = 1'b1;
      r.message_end = 1'b0;
      r.no_payload  = 1'b0;
      return r;
   endfunction

   function automatic result_type marker_result(input logic nopay);
      result_type r;
      r.out_byte    = 8'd0;
      r.byte_valid  = 1'b0;
      r.message_end = 1'b0;
      r.no_payload  = nopay;
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/b64u_req_if.sv]
`default_nettype none
interface b64u_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       char_present;
   logic       end_of_string;

   modport source (output valid, output char_code, output char_present,
                   output end_of_string, input ready);
   modport sink   (input valid, input char_code, input char_present,
                   input end_of_string, output ready);
endinterface
`default_nettype wire

[rtl/b64u_rsp_if.sv]
`default_nettype none
interface b64u_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       message_end;
   logic       no_payload;
   logic       last;

   modport source (output valid, output out_byte, output byte_valid, output message_end,
                   output no_payload, output last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input message_end,
                   input no_payload, input last, output ready);
endinterface
`default_nettype wire

[rtl/b64u_decode.sv]
`default_nettype none
module b64u_decode (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          char_code,
   input  wire logic                char_present,
   input  wire logic                end_of_string,
   output b64u_pkg::batch_type      batch
);

   logic [11:0]             acc_ff, acc_in;
   logic [3:0]              bcnt_ff, bcnt_in;
   logic                    pad_ff, pad_in;
   logic [2:0]              dcnt_ff, dcnt_in;
   logic [7:0]              head_ff [3];
   logic [7:0]              head_in [3];
   b64u_pkg::mode_type      mode_ff, mode_in;
   logic [7:0]              plow_ff, plow_in;
   logic                    plow_valid_ff, plow_valid_in;

   b64u_pkg::sextet_type    sext;
   logic                    have_byte;
   logic [7:0]              new_byte;
   logic [2:0]              last_idx;

   assign sext = b64u_pkg::sextet_of(char_code);

   always_comb begin
      acc_in        = acc_ff;
      bcnt_in       = bcnt_ff;
      pad_in        = pad_ff;
      dcnt_in       = dcnt_ff;
      head_in       = head_ff;
      mode_in       = mode_ff;
      plow_in       = plow_ff;
      plow_valid_in = plow_valid_ff;
      have_byte     = 1'b0;
      new_byte      = 8'd0;
      batch         = '0;
      last_idx      = 3'd0;

      if (char_present && !pad_ff) begin
         if (char_code == b64u_pkg::PAD_CHAR) begin
            pad_in = 1'b1;
         end else if (sext.ok) begin
            acc_in = {acc_ff[5:0], sext.value};
            case (bcnt_ff)
               4'd6: begin
                  have_byte = 1'b1;
                  new_byte  = acc_in[11:4];
                  bcnt_in   = 4'd4;
               end
               4'd4: begin
                  have_byte = 1'b1;
                  new_byte  = acc_in[9:2];
                  bcnt_in   = 4'd2;
               end
               4'd2: begin
                  have_byte = 1'b1;
                  new_byte  = acc_in[7:0];
                  bcnt_in   = 4'd0;
               end
               default: begin
                  bcnt_in = 4'd6;
               end
            endcase
         end
      end

      if (have_byte) begin
         case (mode_ff)
            b64u_pkg::MODE_UNDECIDED: begin
               if (dcnt_ff < 3'd3) begin
                  head_in[dcnt_ff[1:0]] = new_byte;
                  dcnt_in = dcnt_ff + 3'd1;
               end else begin
                  dcnt_in = 3'd4;
                  if (head_ff[1] == 8'd0 && new_byte == 8'd0) begin
                     mode_in = b64u_pkg::MODE_UTF16;
                     if (b64u_pkg::is_text(head_ff[0], head_ff[1]))
                        batch = b64u_pkg::push(batch, b64u_pkg::data_result(head_ff[0]));
                     if (b64u_pkg::is_text(head_ff[2], new_byte))
                        batch = b64u_pkg::push(batch, b64u_pkg::data_result(head_ff[2]));
                  end else begin
                     mode_in = b64u_pkg::MODE_RAW;
                     batch = b64u_pkg::push(batch, b64u_pkg::data_result(head_ff[0]));
                     batch = b64u_pkg::push(batch, b64u_pkg::data_result(head_ff[1]));
                     batch = b64u_pkg::push(batch, b64u_pkg::data_result(head_ff[2]));
                     batch = b64u_pkg::push(batch, b64u_pkg::data_result(new_byte));
                  end
               end
            end
            b64u_pkg::MODE_RAW: begin
               batch = b64u_pkg::push(batch, b64u_pkg::data_result(new_byte));
            end
            b64u_pkg::MODE_UTF16: begin
               if (!plow_valid_ff) begin
                  plow_in       = new_byte;
                  plow_valid_in = 1'b1;
               end else begin
                  if (b64u_pkg::is_text(plow_ff, new_byte))
                     batch = b64u_pkg::push(batch, b64u_pkg::data_result(plow_ff));
                  plow_valid_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      if (end_of_string) begin
         if (mode_in == b64u_pkg::MODE_UNDECIDED) begin
            if (dcnt_in == 3'd0) begin
               batch = b64u_pkg::push(batch, b64u_pkg::marker_result(1'b1));
            end else begin
               // flush a short message raw
               for (int i = 0; i < 3; i++) begin
                  if (3'(i) < dcnt_in)
                     batch = b64u_pkg::push(batch, b64u_pkg::data_result(head_in[i]));
               end
            end
         end else if (batch.count == 3'd0) begin
            batch = b64u_pkg::push(batch, b64u_pkg::marker_result(1'b0));
         end
         last_idx = batch.count - 3'd1;
         batch.entry[last_idx[1:0]].message_end = 1'b1;
         acc_in        = 12'd0;
         bcnt_in       = 4'd0;
         pad_in        = 1'b0;
         dcnt_in       = 3'd0;
         mode_in       = b64u_pkg::MODE_UNDECIDED;
         plow_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= 12'd0;
         bcnt_ff       <= 4'd0;
         pad_ff        <= 1'b0;
         dcnt_ff       <= 3'd0;
         mode_ff       <= b64u_pkg::MODE_UNDECIDED;
         plow_valid_ff <= 1'b0;
      end else if (accept) begin
         acc_ff        <= acc_in;
         bcnt_ff       <= bcnt_in;
         pad_ff        <= pad_in;
         dcnt_ff       <= dcnt_in;
         mode_ff       <= mode_in;
         plow_valid_ff <= plow_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         head_ff <= head_in;
         plow_ff <= plow_in;
      end
   end

endmodule
`default_nettype wire

[rtl/b64u_emit.sv]
`default_nettype none
module b64u_emit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire b64u_pkg::batch_type batch,
   output logic                     free,
   b64u_rsp_if.source               rsp
);

   logic [2:0]                                    count_ff;
   b64u_pkg::result_type [b64u_pkg::MaxResults-1:0] entries_ff;
   logic                                          pop;

   assign rsp.valid       = (count_ff != 3'd0);
   assign rsp.out_byte    = entries_ff[0].out_byte;
   assign rsp.byte_valid  = entries_ff[0].byte_valid;
   assign rsp.message_end = entries_ff[0].message_end;
   assign rsp.no_payload  = entries_ff[0].no_payload;
   assign rsp.last        = (count_ff == 3'd1);

   assign pop  = rsp.valid && rsp.ready;
   // take a new batch when empty or when the final entry leaves this cycle
   assign free = (count_ff == 3'd0) || ((count_ff == 3'd1) && rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else if (load) begin
         count_ff <= batch.count;
      end else if (pop) begin
         count_ff <= count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entries_ff <= batch.entry;
      end else if (pop) begin
         // advance the queue by one
         for (int i = 0; i < b64u_pkg::MaxResults - 1; i++)
            entries_ff[i] <= entries_ff[i+1];
      end
   end

endmodule
`default_nettype wire

[rtl/base64_decoder_utf16_filter.sv]
// The first result of a request is shown in the cycle after it is accepted.
// One request per cycle while each request gives at most one result and the
// receiver does not stall; a request that gives more results (up to four) holds
// req_ch.ready low while the result queue drains, one entry per ready cycle.
// Reset (synchronous, active high) clears the decoder state and empties the queue.
`default_nettype none
module base64_decoder_utf16_filter (
   input  wire logic   clock,
   input  wire logic   reset,
   b64u_req_if.sink    req_ch,
   b64u_rsp_if.source  rsp_ch
);

   logic                  accept;
   logic                  free;
   logic                  load;
   b64u_pkg::batch_type   batch;

   assign req_ch.ready = free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign load         = accept && (batch.count != 3'd0);

   b64u_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .char_code     (req_ch.char_code),
      .char_present  (req_ch.char_present),
      .end_of_string (req_ch.end_of_string),
      .batch         (batch)
   );

   b64u_emit u_emit (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .batch (batch),
      .free  (free),
      .rsp   (rsp_ch)
   );

endmodule
`default_nettype wire

[rtl/b64u_checker.sv]
`default_nettype none
module b64u_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_byte_valid,
   input wire logic       rsp_message_end,
   input wire logic       rsp_no_payload,
   input wire logic       rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled response changed");

   a_marker_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_message_end && (rsp_out_byte == 8'd0))
      else $error("marker response outside message end");

   a_nopay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_payload |-> !rsp_byte_valid && rsp_message_end)
      else $error("no_payload on a data response");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_last)
      else $error("message end not on last response of request");

endmodule

bind base64_decoder_utf16_filter b64u_checker u_b64u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_byte    (rsp_ch.out_byte),
   .rsp_byte_valid  (rsp_ch.byte_valid),
   .rsp_message_end (rsp_ch.message_end),
   .rsp_no_payload  (rsp_ch.no_payload),
   .rsp_last        (rsp_ch.last)
);
`default_nettype wire

[sim/base64_decoder_utf16_filter_tb.sv]
module base64_decoder_utf16_filter_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 200000;
   localparam int TailCycles = 20;
   localparam int LongHold   = 80;

   typedef logic [7:0] byte_list_type[$];

   typedef struct {
      logic [7:0] code;
      logic       present;
      logic       eos;
      int         gap;
      bit         drain;
   } char_request_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       message_end;
      logic       no_payload;
      logic       last;
   } decoded_byte_type;

   logic clock = 1'b0;
   logic reset;

   b64u_req_if req_ch ();
   b64u_rsp_if rsp_ch ();

   base64_decoder_utf16_filter DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   char_request_type pending_chars[$];
   decoded_byte_type expected_bytes[$];
   decoded_byte_type step_bytes[$];

   int  cycle_count    = 0;
   int  requests_taken = 0;
   int  results_seen   = 0;
   int  mismatches     = 0;
   int  send_calm      = 0;
   int  recv_calm      = 0;
   int  stall_left     = 0;
   bit  long_hold_done = 1'b0;
   bit  staged         = 1'b0;
   int  idle_left      = 0;
   logic req_taken;
   char_request_type cur_char;

   // decoder state mirror
   logic [11:0]        bit_acc;
   logic [3:0]         bit_count;
   logic               pad_seen;
   logic [2:0]         byte_count;
   logic [7:0]         head_bytes [3];
   b64u_pkg::mode_type out_mode;
   logic [7:0]         low_byte;
   logic               low_valid;

   function automatic int sextet_value(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - int'("A");
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
      if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
   endfunction

   function automatic logic [7:0] base64_char(input logic [5:0] v);
      if (v < 26) return 8'("A") + 8'(v);
      if (v < 52) return 8'("a") + 8'(v - 26);
      if (v < 62) return 8'("0") + 8'(v - 52);
      if (v == 62) return 8'("+");
      return 8'("/");
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      do c = 8'($urandom); while (sextet_value(c) >= 0 || c == b64u_pkg::PAD_CHAR);
      return c;
   endfunction

   // mostly short gaps, a few long ones, and now and then a calm stretch
   function automatic int draw_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(15, 40);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 45);
   endfunction

   task automatic clear_decoder();
      bit_acc    = '0;
      bit_count  = '0;
      pad_seen   = 1'b0;
      byte_count = '0;
      head_bytes = '{default: 8'h00};
      out_mode   = b64u_pkg::MODE_UNDECIDED;
      low_byte   = 8'h00;
      low_valid  = 1'b0;
   endtask

   task automatic add_byte(input logic [7:0] value, input logic valid, input logic nopay);
      decoded_byte_type d;
      d.out_byte    = value;
      d.byte_valid  = valid;
      d.message_end = 1'b0;
      d.no_payload  = nopay;
      d.last        = 1'b0;
      if (step_bytes.size() < b64u_pkg::MaxResults) step_bytes.insert(step_bytes.size(), d);
   endtask

   task automatic add_text_pair(input logic [7:0] lo, input logic [7:0] hi);
      if (hi == 8'h00 && ((lo >= b64u_pkg::TEXT_LOW && lo <= b64u_pkg::TEXT_HIGH) ||
                          lo == b64u_pkg::CHAR_TAB || lo == b64u_pkg::CHAR_LF ||
                          lo == b64u_pkg::CHAR_CR))
         add_byte(lo, 1'b1, 1'b0);
   endtask

   task automatic route_byte(input logic [7:0] b);
      case (out_mode)
         b64u_pkg::MODE_UNDECIDED: begin
            if (byte_count < 3) begin
               head_bytes[byte_count[1:0]] = b;
               byte_count++;
            end else begin
               byte_count = 3'd4;
               if (head_bytes[1] == 8'h00 && b == 8'h00) begin
                  out_mode = b64u_pkg::MODE_UTF16;
                  add_text_pair(head_bytes[0], head_bytes[1]);
                  add_text_pair(head_bytes[2], b);
               end else begin
                  out_mode = b64u_pkg::MODE_RAW;
                  add_byte(head_bytes[0], 1'b1, 1'b0);
                  add_byte(head_bytes[1], 1'b1, 1'b0);
                  add_byte(head_bytes[2], 1'b1, 1'b0);
                  add_byte(b, 1'b1, 1'b0);
               end
            end
         end
         b64u_pkg::MODE_RAW: add_byte(b, 1'b1, 1'b0);
         default: begin
            if (!low_valid) begin
               low_byte  = b;
               low_valid = 1'b1;
            end else begin
               add_text_pair(low_byte, b);
               low_valid = 1'b0;
            end
         end
      endcase
   endtask

   task automatic predict_request(input logic [7:0] code, input logic present, input logic eos);
      int d;
      int total;
      int i;
      step_bytes.delete();
      if (present && !pad_seen) begin
         if (code == b64u_pkg::PAD_CHAR) begin
            pad_seen = 1'b1;
         end else begin
            d = sextet_value(code);
            if (d >= 0) begin
               total   = int'(bit_count) + 6;
               bit_acc = {bit_acc[5:0], 6'(d)};
               if (total >= 8) begin
                  bit_count = 4'(total - 8);
                  route_byte(8'(bit_acc >> (total - 8)));
               end else begin
                  bit_count = 4'(total);
               end
            end
         end
      end
      if (eos) begin
         if (out_mode == b64u_pkg::MODE_UNDECIDED) begin
            if (byte_count == 0) begin
               add_byte(8'h00, 1'b0, 1'b1);
            end else begin
               for (i = 0; i < int'(byte_count) && i < 3; i++)
                  add_byte(head_bytes[i], 1'b1, 1'b0);
            end
         end else if (step_bytes.size() == 0) begin
            add_byte(8'h00, 1'b0, 1'b0);
         end
         step_bytes[step_bytes.size()-1].message_end = 1'b1;
         clear_decoder();
      end
      if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last = 1'b1;
      foreach (step_bytes[k]) expected_bytes.insert(expected_bytes.size(), step_bytes[k]);
   endtask

   task automatic push_request(input logic [7:0] code, input logic present, input logic eos);
      char_request_type r;
      r.code    = code;
      r.present = present;
      r.eos     = eos;
      // back-to-back stretch so the long receiver hold-off fills the block
      r.gap     = (pending_chars.size() >= 25 && pending_chars.size() < 70) ?
                  0 : draw_gap(send_calm);
      r.drain   = (pending_chars.size() == 90);
      pending_chars.insert(pending_chars.size(), r);
   endtask

   task automatic push_encoded(input byte_list_type data, input bit with_pad, input bit tail,
                               input int noise_pct, input bit end_apart);
      logic [7:0]  chars[$];
      logic [23:0] group;
      int          i;
      int          k;
      int          left;
      int          nch;
      i = 0;
      while (i < data.size()) begin
         left  = data.size() - i;
         group = {data[i], (left > 1) ? data[i+1] : 8'h00, (left > 2) ? data[i+2] : 8'h00};
         nch   = (left >= 3) ? 4 : left + 1;
         for (k = 0; k < nch; k++)
            chars.insert(chars.size(), base64_char(group[23-6*k -: 6]));
         if (with_pad)
            for (k = nch; k < 4; k++) chars.insert(chars.size(), b64u_pkg::PAD_CHAR);
         i += 3;
      end
      // characters after a pad must be ignored
      if (tail) begin
         chars.insert(chars.size(), b64u_pkg::PAD_CHAR);
         repeat ($urandom_range(1, 3)) chars.insert(chars.size(), base64_char(6'($urandom)));
      end
      if (chars.size() == 0) end_apart = 1'b1;
      foreach (chars[j]) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            if ($urandom_range(0, 1) == 0) push_request(noise_char(), 1'b1, 1'b0);
            else push_request(8'($urandom), 1'b0, 1'b0);
         end
         push_request(chars[j], 1'b1, !end_apart && j == chars.size() - 1);
      end
      if (end_apart) push_request(8'($urandom), 1'b0, 1'b1);
   endtask

   // driver: present the next request once the previous one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid         <= 1'b0;
         req_ch.char_code     <= 8'h00;
         req_ch.char_present  <= 1'b0;
         req_ch.end_of_string <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (!staged && pending_chars.size() > 0) begin
            cur_char  = pending_chars.pop_front();
            staged    = 1'b1;
            idle_left = cur_char.gap;
         end
         if (staged && idle_left > 0) begin
            idle_left--;
            req_ch.valid <= 1'b0;
         end else if (staged && cur_char.drain && expected_bytes.size() > 0) begin
            req_ch.valid <= 1'b0;
         end else if (staged) begin
            req_ch.char_code     <= cur_char.code;
            req_ch.char_present  <= cur_char.present;
            req_ch.end_of_string <= cur_char.eos;
            req_ch.valid         <= 1'b1;
            staged = 1'b0;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver backpressure, with one long hold-off while requests keep coming
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!long_hold_done && requests_taken >= 30) begin
            stall_left     = LongHold;
            long_hold_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = draw_gap(recv_calm);
         end
      end
   end

   // monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin : monitor
      decoded_byte_type want;
      cycle_count++;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            predict_request(req_ch.char_code, req_ch.char_present, req_ch.end_of_string);
            requests_taken++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_bytes.size() == 0) begin
               if (mismatches < 10)
                  $display("result %0d: unexpected byte %02h valid %b end %b nopay %b last %b",
                           results_seen, rsp_ch.out_byte, rsp_ch.byte_valid,
                           rsp_ch.message_end, rsp_ch.no_payload, rsp_ch.last);
               mismatches++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_ch.out_byte !== want.out_byte || rsp_ch.byte_valid !== want.byte_valid ||
                   rsp_ch.message_end !== want.message_end ||
                   rsp_ch.no_payload !== want.no_payload || rsp_ch.last !== want.last) begin
                  if (mismatches < 10)
                     $display({"result %0d: want byte %02h valid %b end %b nopay %b last %b,",
                               " got byte %02h valid %b end %b nopay %b last %b"},
                              results_seen, want.out_byte, want.byte_valid, want.message_end,
                              want.no_payload, want.last, rsp_ch.out_byte, rsp_ch.byte_valid,
                              rsp_ch.message_end, rsp_ch.no_payload, rsp_ch.last);
                  mismatches++;
               end
            end
            results_seen++;
         end
      end
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("base64_decoder_utf16_filter: mismatch");
      $finish;
   end

   initial begin
      byte_list_type data;
      int            kind;
      int            len;
      int            i;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.char_code     = 8'h00;
      req_ch.char_present  = 1'b0;
      req_ch.end_of_string = 1'b0;
      rsp_ch.ready         = 1'b0;
      clear_decoder();

      // empty message, then one made only of non-alphabet characters
      push_request(8'h00, 1'b0, 1'b1);
      push_request(8'hFF, 1'b1, 1'b0);
      push_request(8'h00, 1'b1, 1'b1);
      // one byte, pad, then a character that must be ignored
      push_request("Q", 1'b1, 1'b0);
      push_request("Q", 1'b1, 1'b0);
      push_request(b64u_pkg::PAD_CHAR, 1'b1, 1'b0);
      push_request("Z", 1'b1, 1'b1);
      // raw bytes with '+' and '/' in the encoding
      data = '{8'hFB, 8'hEF, 8'hBE, 8'hFF, 8'h3E};
      push_encoded(data, 1'b1, 1'b0, 0, 1'b0);
      // text pairs: tab, tilde, then an odd CR that is dropped
      data = '{b64u_pkg::CHAR_TAB, 8'h00, b64u_pkg::TEXT_HIGH, 8'h00, b64u_pkg::CHAR_CR};
      push_encoded(data, 1'b1, 1'b0, 0, 1'b0);

      while (pending_chars.size() < 100) begin
         kind = $urandom_range(0, 99);
         data.delete();
         if (kind < 35) begin
            len = $urandom_range(4, 12);
            for (i = 0; i < len; i++) begin
               if (i == 1 || i == 3) data.insert(data.size(), 8'h00);
               else if (i % 2 == 1)
                  data.insert(data.size(),
                              ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
               else if ($urandom_range(0, 99) < 70)
                  data.insert(data.size(), 8'($urandom_range(32, 126)));
               else if ($urandom_range(0, 1) == 0)
                  data.insert(data.size(),
                              ($urandom_range(0, 2) == 0) ? b64u_pkg::CHAR_TAB :
                              ($urandom_range(0, 1) == 0) ? b64u_pkg::CHAR_LF :
                              b64u_pkg::CHAR_CR);
               else data.insert(data.size(), 8'($urandom));
            end
         end else if (kind < 62) begin
            len = $urandom_range(4, 10);
            for (i = 0; i < len; i++) data.insert(data.size(), 8'($urandom));
            if ($urandom_range(0, 3) == 0) data[1] = 8'h00;
            else if ($urandom_range(0, 3) == 0) data[3] = 8'h00;
         end else if (kind < 77) begin
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++) data.insert(data.size(), 8'($urandom));
         end else if (kind < 85) begin
            if ($urandom_range(0, 1) == 0) begin
               push_request(8'($urandom), 1'b0, 1'b1);
            end else begin
               repeat ($urandom_range(1, 3)) push_request(noise_char(), 1'b1, 1'b0);
               push_request(noise_char(), 1'b1, 1'b1);
            end
         end else begin
            // broken sequence: alphabet, pads and arbitrary bytes mixed
            len = $urandom_range(1, 8);
            for (i = 0; i < len; i++) begin
               kind = $urandom_range(0, 9);
               push_request((kind < 5) ? base64_char(6'($urandom)) :
                            (kind < 7) ? b64u_pkg::PAD_CHAR : 8'($urandom),
                            1'b1, i == len - 1);
            end
            kind = 99;
         end
         if (kind < 77)
            push_encoded(data, $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0,
                         ($urandom_range(0, 3) == 0) ? 15 : 0, $urandom_range(0, 2) == 0);
      end

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      do @(posedge clock);
      while (pending_chars.size() > 0 || staged || req_ch.valid || expected_bytes.size() > 0);
      repeat (TailCycles) @(posedge clock);
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("base64_decoder_utf16_filter: match");
      end else begin
         $display("base64_decoder_utf16_filter: mismatch");
      end
      $finish;
   end

endmodule
